/* rtl/kvt_pkg.sv */
// kvt_pkg: shared constants, codes and types for the key velocity tracker.
// No dependencies; every other file refers to it by scoped names.
package kvt_pkg;

  localparam int KEYS        = 24;
  localparam int KEY_W       = 5;
  localparam int SAMPLE_BITS = 12;
  localparam int TIME_W      = 32;
  localparam int WIN_W       = 16;
  localparam int MODE_W      = 2;
  localparam int SEL_W       = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(512);

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEVEL  = 2'd2;

  // threshold selects
  localparam logic [SEL_W-1:0] LVL_START   = 2'd0;
  localparam logic [SEL_W-1:0] LVL_PRESS   = 2'd1;
  localparam logic [SEL_W-1:0] LVL_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_PRESS = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   start_time;
  } key_rec_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] start_lvl;
    logic [SAMPLE_BITS-1:0] press_lvl;
    logic [SAMPLE_BITS-1:0] release_lvl;
  } key_lvl_t;

  // phase/start-time write-back
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    key_rec_t         rec;
  } rec_wr_t;

  // threshold write: one enable per level (start, press, release)
  typedef struct packed {
    logic [2:0]             en;
    logic [KEY_W-1:0]       key;
    logic [SAMPLE_BITS-1:0] value;
  } lvl_wr_t;

endpackage

/* rtl/kvt_if.sv */
// kvt_if: valid/ready channel interfaces for input, result and config.
// Depends on kvt_pkg for field widths.
interface kvt_in_if;
  logic                            valid;
  logic                            ready;
  logic [kvt_pkg::MODE_W-1:0]      mode;
  logic [kvt_pkg::KEY_W-1:0]       key;
  logic [kvt_pkg::SEL_W-1:0]       level_select;
  logic [kvt_pkg::SAMPLE_BITS-1:0] value;
  modport source (output valid, mode, key, level_select, value, input ready);
  modport sink   (input valid, mode, key, level_select, value, output ready);
endinterface

interface kvt_out_if;
  logic                       valid;
  logic                       ready;
  logic [kvt_pkg::KEY_W-1:0]  out_key;
  logic                       is_press;
  logic [kvt_pkg::WIN_W-1:0]  elapsed;
  modport source (output valid, out_key, is_press, elapsed, input ready);
  modport sink   (input valid, out_key, is_press, elapsed, output ready);
endinterface

interface kvt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kvt_pkg::WIN_W-1:0]  press_window;
  modport source (output valid, press_window, input ready);
  modport sink   (input valid, press_window, output ready);
endinterface

/* rtl/kvt_key_store.sv */
// kvt_key_store: per-key memories (phase + start time, three thresholds),
// with a registered read. Depends on kvt_pkg.
module kvt_key_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [kvt_pkg::KEY_W-1:0]     rd_key,
  input  kvt_pkg::rec_wr_t              rec_wr,
  input  kvt_pkg::lvl_wr_t              lvl_wr,
  output kvt_pkg::key_rec_t             rd_rec,
  output kvt_pkg::key_lvl_t             rd_lvl
);

  kvt_pkg::key_rec_t             rec_mem [kvt_pkg::KEYS];
  logic [kvt_pkg::SAMPLE_BITS-1:0] st_mem [kvt_pkg::KEYS];
  logic [kvt_pkg::SAMPLE_BITS-1:0] pr_mem [kvt_pkg::KEYS];
  logic [kvt_pkg::SAMPLE_BITS-1:0] rl_mem [kvt_pkg::KEYS];

  logic [kvt_pkg::KEYS-1:0] vld_r;
  logic                     rd_vld_r;
  kvt_pkg::key_rec_t        rec_q_r;

  // valid bit per key: an unwritten record reads as idle, time 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rec_wr.en) vld_r[rec_wr.key] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_key];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_wr.en) rec_mem[rec_wr.key] <= rec_wr.rec;
    if (rd_en) rec_q_r <= rec_mem[rd_key];
  end

  always_ff @(posedge clk) begin
    if (lvl_wr.en[0]) st_mem[lvl_wr.key] <= lvl_wr.value;
    if (lvl_wr.en[1]) pr_mem[lvl_wr.key] <= lvl_wr.value;
    if (lvl_wr.en[2]) rl_mem[lvl_wr.key] <= lvl_wr.value;
    if (rd_en) begin
      rd_lvl.start_lvl   <= st_mem[rd_key];
      rd_lvl.press_lvl   <= pr_mem[rd_key];
      rd_lvl.release_lvl <= rl_mem[rd_key];
    end
  end

  always_comb begin
    if (rd_vld_r) begin
      rd_rec = rec_q_r;
    end else begin
      rd_rec.phase      = kvt_pkg::PH_IDLE;
      rd_rec.start_time = '0;
    end
  end

endmodule

/* rtl/key_velocity_tracker.sv */
// key_velocity_tracker: per-key idle/start/press tracker for analog key sensors.
// A result passes stage 1 and then the output register before it appears on out_ch.
// Throughput: one item per cycle while out_ch is not stalled; the key read-modify-write
// loop is a memory read then a compute/write-back, closed by write-back forwarding.
// Reset: phase valid bits cleared at once (all keys idle, start time 0), tick 0,
// press_window 512; thresholds undefined until written, no clearing pass.
// Depends on kvt_pkg, kvt_if.sv and kvt_key_store.
module key_velocity_tracker (
  input  logic            clk,
  input  logic            rst_n,
  kvt_in_if.sink          in_ch,
  kvt_out_if.source       out_ch,
  kvt_cfg_if.sink         cfg_ch
);

  // config register
  logic [kvt_pkg::WIN_W-1:0] press_window_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_window_r <= kvt_pkg::WINDOW_RESET;
    end else if (cfg_ch.valid) begin
      press_window_r <= cfg_ch.press_window;
    end
  end

  // stage 1: item whose memory read has returned
  logic                            s1_valid_r;
  logic [kvt_pkg::MODE_W-1:0]      s1_mode_r;
  logic [kvt_pkg::KEY_W-1:0]       s1_key_r;
  logic [kvt_pkg::SEL_W-1:0]       s1_sel_r;
  logic [kvt_pkg::SAMPLE_BITS-1:0] s1_value_r;
  logic                            s1_inrange_r;

  logic [kvt_pkg::TIME_W-1:0]      tick_r;

  // forwarding of the write-back that lands on the edge of our read
  logic                            fwd_rec_hit_r;
  kvt_pkg::key_rec_t               fwd_rec_r;
  logic [2:0]                      fwd_lvl_hit_r;
  logic [kvt_pkg::SAMPLE_BITS-1:0] fwd_lvl_r;

  // output register
  logic                            out_valid_r;
  logic [kvt_pkg::KEY_W-1:0]       out_key_r;
  logic                            out_press_r;
  logic [kvt_pkg::WIN_W-1:0]       out_elapsed_r;

  logic                s1_adv;
  logic                in_xfer;
  logic                in_range;
  kvt_pkg::rec_wr_t    rec_wr;
  kvt_pkg::lvl_wr_t    lvl_wr;
  kvt_pkg::key_rec_t   mem_rec;
  kvt_pkg::key_lvl_t   mem_lvl;
  kvt_pkg::key_rec_t   cur_rec;
  kvt_pkg::key_lvl_t   cur_lvl;
  kvt_pkg::key_rec_t   new_rec;
  logic                emit;
  logic                emit_press;
  logic [kvt_pkg::TIME_W-1:0] el;

  // stage 1 moves on once the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_range = in_ch.key < kvt_pkg::KEY_W'(kvt_pkg::KEYS);

  kvt_key_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_xfer && in_range),
    .rd_key (in_ch.key),
    .rec_wr (rec_wr),
    .lvl_wr (lvl_wr),
    .rd_rec (mem_rec),
    .rd_lvl (mem_lvl)
  );

  // merge memory data with the forwarded write
  always_comb begin
    cur_rec = fwd_rec_hit_r ? fwd_rec_r : mem_rec;
    cur_lvl = mem_lvl;
    if (fwd_lvl_hit_r[0]) cur_lvl.start_lvl   = fwd_lvl_r;
    if (fwd_lvl_hit_r[1]) cur_lvl.press_lvl   = fwd_lvl_r;
    if (fwd_lvl_hit_r[2]) cur_lvl.release_lvl = fwd_lvl_r;
  end

  // per-key phase update
  always_comb begin
    new_rec    = cur_rec;
    emit       = 1'b0;
    emit_press = 1'b0;
    el         = tick_r - cur_rec.start_time;
    unique case (cur_rec.phase)
      kvt_pkg::PH_IDLE: begin
        if (s1_value_r >= cur_lvl.start_lvl) begin
          new_rec.phase      = kvt_pkg::PH_START;
          new_rec.start_time = tick_r;
        end
      end
      kvt_pkg::PH_START: begin
        if (s1_value_r < cur_lvl.start_lvl) begin
          new_rec.phase      = kvt_pkg::PH_IDLE;
          new_rec.start_time = '0;
        end else if (s1_value_r > cur_lvl.press_lvl) begin
          new_rec.phase = kvt_pkg::PH_PRESS;
          // strictly inside the window reports a press
          if (el < {{(kvt_pkg::TIME_W-kvt_pkg::WIN_W){1'b0}}, press_window_r}) begin
            emit       = 1'b1;
            emit_press = 1'b1;
          end
        end
      end
      kvt_pkg::PH_PRESS: begin
        if (s1_value_r <= cur_lvl.release_lvl) begin
          emit = 1'b1;
          if (s1_value_r > cur_lvl.start_lvl) begin
            new_rec.phase      = kvt_pkg::PH_START;
            new_rec.start_time = tick_r;
          end else begin
            new_rec.phase      = kvt_pkg::PH_IDLE;
            new_rec.start_time = '0;
          end
        end
      end
      default: begin
        new_rec.phase      = kvt_pkg::PH_IDLE;
        new_rec.start_time = '0;
      end
    endcase
  end

  // write-back requests
  always_comb begin
    rec_wr.en    = s1_adv && s1_inrange_r && (s1_mode_r == kvt_pkg::MODE_SAMPLE);
    rec_wr.key   = s1_key_r;
    rec_wr.rec   = new_rec;
    lvl_wr.key   = s1_key_r;
    lvl_wr.value = s1_value_r;
    lvl_wr.en    = 3'b000;
    if (s1_adv && s1_inrange_r && (s1_mode_r == kvt_pkg::MODE_LEVEL)) begin
      lvl_wr.en[0] = (s1_sel_r == kvt_pkg::LVL_START);
      lvl_wr.en[1] = (s1_sel_r == kvt_pkg::LVL_PRESS);
      lvl_wr.en[2] = (s1_sel_r == kvt_pkg::LVL_RELEASE);
    end
  end

  // stage 1 control, tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      tick_r     <= '0;
    end else begin
      if (in_xfer) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv && (s1_mode_r == kvt_pkg::MODE_TICK)) tick_r <= tick_r + kvt_pkg::TIME_W'(1);
    end
  end

  // stage 1 payload and forwarding capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r     <= in_ch.mode;
      s1_key_r      <= in_ch.key;
      s1_sel_r      <= in_ch.level_select;
      s1_value_r    <= in_ch.value;
      s1_inrange_r  <= in_range;
      fwd_rec_hit_r <= rec_wr.en && (rec_wr.key == in_ch.key);
      fwd_rec_r     <= rec_wr.rec;
      fwd_lvl_hit_r <= lvl_wr.en & {3{lvl_wr.key == in_ch.key}};
      fwd_lvl_r     <= lvl_wr.value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_inrange_r && (s1_mode_r == kvt_pkg::MODE_SAMPLE) && emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_key_r     <= s1_key_r;
      out_press_r   <= emit_press;
      out_elapsed_r <= emit_press ? el[kvt_pkg::WIN_W-1:0] : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_key  = out_key_r;
  assign out_ch.is_press = out_press_r;
  assign out_ch.elapsed  = out_elapsed_r;

endmodule
